[rtl/ffa_pkg.sv]
// Shared constants and types for the first-fit contiguous block allocator.
// Used by every module of the allocator and by its port checker.
`default_nettype none

package ffa_pkg;

    localparam int DEF_NUM_BLOCKS = 256;
    localparam int DEF_OWNER_BITS = 8;

    // Fixed widths of the stream and register fields.
    localparam int OWNER_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int START_W  = 8;
    localparam int USABLE_W = 9;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    localparam logic [USABLE_W-1:0] USABLE_RESET = 9'd256;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_NOSPACE = 1'b1;

    typedef struct packed {
        logic busy_we;
        logic busy_wd;
        logic owner_we;
    } map_wr_t;

    typedef struct packed {
        logic               status;
        logic [START_W-1:0] start_block;
    } result_t;

endpackage

`default_nettype wire

[rtl/ffa_map.sv]
// Busy bitmap and owner tag memories, one read port and one write port each.
// Depends on ffa_pkg for the write control struct.
`default_nettype none

module ffa_map #(
    parameter int NUM_BLOCKS = 256,
    parameter int OWNER_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic [$clog2(NUM_BLOCKS)-1:0] rd_addr,
    input  wire logic [$clog2(NUM_BLOCKS)-1:0] wr_addr,
    input  wire ffa_pkg::map_wr_t              wr,
    input  wire logic [OWNER_BITS-1:0]         wr_owner,
    output logic                               rd_busy,
    output logic [OWNER_BITS-1:0]              rd_owner
);
    import ffa_pkg::*;

    logic                  busy_mem  [NUM_BLOCKS];
    logic [OWNER_BITS-1:0] owner_mem [NUM_BLOCKS];

    always_ff @(posedge aclk) begin
        if (wr.busy_we) begin
            busy_mem[wr_addr] <= wr.busy_wd;
        end
        if (wr.owner_we) begin
            owner_mem[wr_addr] <= wr_owner;
        end
        rd_busy  <= busy_mem[rd_addr];
        rd_owner <= owner_mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/ffa_ctrl.sv]
// Sequencer that walks the block maps one block per cycle for allocate,
// mark and release, plus the clearing pass after reset. Uses ffa_pkg.
`default_nettype none

module ffa_ctrl #(
    parameter int NUM_BLOCKS = 256,
    parameter int OWNER_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic                          req_op,
    input  wire logic [ffa_pkg::OWNER_W-1:0]   req_owner,
    input  wire logic [ffa_pkg::COUNT_W-1:0]   req_count,
    input  wire logic [ffa_pkg::USABLE_W-1:0]  usable,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output ffa_pkg::result_t                   res,
    output logic [$clog2(NUM_BLOCKS)-1:0]      map_rd_addr,
    output logic [$clog2(NUM_BLOCKS)-1:0]      map_wr_addr,
    output ffa_pkg::map_wr_t                   map_wr,
    output logic [OWNER_BITS-1:0]              map_wr_owner,
    input  wire logic                          map_rd_busy,
    input  wire logic [OWNER_BITS-1:0]         map_rd_owner
);
    import ffa_pkg::*;

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_REL   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]            state_reg,     state_next;
    logic [LW-1:0]         pos_reg,       pos_next;
    logic [IW-1:0]         chk_reg,       chk_next;
    logic                  chk_vld_reg,   chk_vld_next;
    logic [LW-1:0]         run_len_reg,   run_len_next;
    logic [IW-1:0]         run_start_reg, run_start_next;
    logic [LW-1:0]         count_reg,     count_next;
    logic [OWNER_BITS-1:0] who_reg,       who_next;
    result_t               res_reg,       res_next;

    logic [LW-1:0]               lim;
    logic                        issue;
    logic [LW-1:0]               new_len;
    logic                        run_hit;
    logic [IW-1:0]               hit_start;
    logic [IW+START_W-1:0]       start_ext;
    logic [OWNER_BITS+OWNER_W-1:0] owner_ext;

    always_comb begin
        lim       = (LW'(usable) > LW'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS) : LW'(usable);
        issue     = (pos_reg < lim);
        new_len   = run_len_reg + LW'(1);
        run_hit   = chk_vld_reg && !map_rd_busy && (new_len >= count_reg);
        hit_start = (run_len_reg == '0) ? chk_reg : run_start_reg;
        start_ext = {{START_W{1'b0}}, hit_start};
        owner_ext = {{OWNER_BITS{1'b0}}, req_owner};
    end

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        chk_next       = chk_reg;
        chk_vld_next   = chk_vld_reg;
        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        count_next     = count_reg;
        who_next       = who_reg;
        res_next       = res_reg;
        req_ready      = 1'b0;
        res_valid      = 1'b0;
        map_rd_addr    = pos_reg[IW-1:0];
        map_wr_addr    = chk_reg;
        map_wr         = '0;
        map_wr_owner   = who_reg;

        unique case (state_reg)
            S_CLEAR: begin
                map_wr_addr    = pos_reg[IW-1:0];
                map_wr.busy_we = 1'b1;
                map_wr.busy_wd = 1'b0;
                pos_next       = pos_reg + LW'(1);
                if (pos_reg == LW'(NUM_BLOCKS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    who_next     = owner_ext[OWNER_BITS-1:0];
                    count_next   = LW'(req_count);
                    pos_next     = '0;
                    chk_vld_next = 1'b0;
                    run_len_next = '0;
                    state_next   = (req_op == OP_RELEASE) ? S_REL : S_SCAN;
                end
            end
            S_SCAN: begin
                // Reads run one block ahead of the evaluated block.
                pos_next     = issue ? pos_reg + LW'(1) : pos_reg;
                chk_next     = pos_reg[IW-1:0];
                chk_vld_next = issue;
                if (chk_vld_reg) begin
                    if (map_rd_busy) begin
                        run_len_next = '0;
                    end else begin
                        run_len_next   = new_len;
                        run_start_next = hit_start;
                    end
                end
                if (run_hit) begin
                    res_next.status      = STAT_OK;
                    res_next.start_block = start_ext[START_W-1:0];
                    if (count_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        run_start_next = hit_start;
                        run_len_next   = count_reg;
                        state_next     = S_MARK;
                    end
                end else if (!issue) begin
                    // The last usable block has been evaluated without a fit.
                    res_next.status      = STAT_NOSPACE;
                    res_next.start_block = '0;
                    state_next           = S_DONE;
                end
            end
            S_MARK: begin
                map_wr_addr     = run_start_reg;
                map_wr.busy_we  = 1'b1;
                map_wr.busy_wd  = 1'b1;
                map_wr.owner_we = 1'b1;
                run_start_next  = run_start_reg + IW'(1);
                run_len_next    = run_len_reg - LW'(1);
                if (run_len_reg == LW'(1)) begin
                    state_next = S_DONE;
                end
            end
            S_REL: begin
                pos_next     = issue ? pos_reg + LW'(1) : pos_reg;
                chk_next     = pos_reg[IW-1:0];
                chk_vld_next = issue;
                if (chk_vld_reg && map_rd_busy && (map_rd_owner == who_reg)) begin
                    map_wr.busy_we = 1'b1;
                    map_wr.busy_wd = 1'b0;
                end
                if (!issue) begin
                    res_next.status      = STAT_OK;
                    res_next.start_block = '0;
                    state_next           = S_DONE;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
        chk_reg       <= chk_next;
        chk_vld_reg   <= chk_vld_next;
        run_len_reg   <= run_len_next;
        run_start_reg <= run_start_next;
        count_reg     <= count_next;
        who_reg       <= who_next;
        res_reg       <= res_next;
    end

endmodule

`default_nettype wire

[rtl/first_fit_contiguous_block_allocator.sv]
// Top level of the first-fit contiguous block allocator: register, output stage,
// sequencer and block maps. Depends on ffa_pkg, ffa_ctrl and ffa_map.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/s_tready  tdata owner[7:0] count[16:8]; tuser op
//   m_        out        m_tvalid/m_tready  tdata start_block[7:0]; tuser status
//   cfg_      in         cfg_wr_en          cfg_wr_data usable_blocks[8:0]
//
// An allocate request scans up to L blocks, then marks each block of the run it
// found, and a release scans all L blocks, where L is the usable block count:
// the sequencer reads one block per cycle through the single read port of the
// block maps. After reset a clearing pass marks every block free in the busy map,
// and s_tready stays low meanwhile. A result waits in the output register while
// the next request is taken; a stalled m_ side holds the sequencer only when
// a second result is ready before the first is taken.
`default_nettype none

module first_fit_contiguous_block_allocator #(
    parameter int NUM_BLOCKS = ffa_pkg::DEF_NUM_BLOCKS,
    parameter int OWNER_BITS = ffa_pkg::DEF_OWNER_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ffa_pkg::S_DATA_W-1:0]   s_tdata,   // owner, count, zero fill
    input  wire logic                           s_tuser,   // op
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ffa_pkg::M_DATA_W-1:0]        m_tdata,   // start_block
    output logic                                m_tuser,   // status
    input  wire logic                           cfg_wr_en,
    input  wire logic [ffa_pkg::USABLE_W-1:0]   cfg_wr_data
);
    import ffa_pkg::*;

    localparam int IW = $clog2(NUM_BLOCKS);

    logic [USABLE_W-1:0]   usable_reg;
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic                  m_tuser_reg;

    logic                  res_valid;
    logic                  res_ready;
    result_t               res;
    logic [IW-1:0]         map_rd_addr;
    logic [IW-1:0]         map_wr_addr;
    map_wr_t               map_wr;
    logic [OWNER_BITS-1:0] map_wr_owner;
    logic                  map_rd_busy;
    logic [OWNER_BITS-1:0] map_rd_owner;

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            usable_reg   <= USABLE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                usable_reg <= cfg_wr_data;
            end
            if (res_valid && res_ready) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (res_valid && res_ready) begin
            m_tdata_reg <= res.start_block;
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    ffa_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .OWNER_BITS (OWNER_BITS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req_op       (s_tuser),
        .req_owner    (s_tdata[OWNER_W-1:0]),
        .req_count    (s_tdata[OWNER_W+COUNT_W-1:OWNER_W]),
        .usable       (usable_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .map_rd_addr  (map_rd_addr),
        .map_wr_addr  (map_wr_addr),
        .map_wr       (map_wr),
        .map_wr_owner (map_wr_owner),
        .map_rd_busy  (map_rd_busy),
        .map_rd_owner (map_rd_owner)
    );

    ffa_map #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .OWNER_BITS (OWNER_BITS)
    ) u_map (
        .aclk     (aclk),
        .rd_addr  (map_rd_addr),
        .wr_addr  (map_wr_addr),
        .wr       (map_wr),
        .wr_owner (map_wr_owner),
        .rd_busy  (map_rd_busy),
        .rd_owner (map_rd_owner)
    );

endmodule

`default_nettype wire

[rtl/ffa_checker.sv]
// Port-level checks for the block allocator, bound to its top level.
// Depends on ffa_pkg for field widths and status codes.
`default_nettype none

module ffa_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [ffa_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                         m_tuser
);
    import ffa_pkg::*;

    // The clearing pass keeps requests out right after reset.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request accepted during the clearing pass");

    // A request keeps the sequencer busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted in back-to-back cycles");

    // A failed allocation reports block zero.
    a_fail_zero_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_NOSPACE) |-> (m_tdata == '0))
        else $error("failed request reports a nonzero start block");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

endmodule

bind first_fit_contiguous_block_allocator ffa_checker u_ffa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
